### rtl/core/oams_pkg.sv
`default_nettype none
package oams_pkg;

	// Largest backward run in a dead-end escape
	localparam int MAX_BACKUP = 16;
	// Pending run length: up to MAX_BACKUP backward moves, a turn and a forward
	localparam int CNT_W = $clog2(MAX_BACKUP + 2);

	localparam int DRIVE_W    = 3;
	localparam int CLEAN_W    = 2;
	localparam int BOOST_W    = 16;
	localparam int BACKUP_W   = 5;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [BOOST_W-1:0]  BOOST_DURATION_RST = 16'd20;
	localparam logic [BACKUP_W-1:0] BACKUP_TICKS_RST   = 5'd3;

	// Register select, taken from paddr[2]
	localparam logic REG_BOOST_DURATION = 1'b0;
	localparam logic REG_BACKUP_TICKS   = 1'b1;

	typedef enum logic [DRIVE_W-1:0] {
		DRV_FWD   = 3'd0,
		DRV_BACK  = 3'd1,
		DRV_LEFT  = 3'd2,
		DRV_RIGHT = 3'd3,
		DRV_STOP  = 3'd4
	} drive_t;

	typedef enum logic [CLEAN_W-1:0] {
		CLN_OFF    = 2'd0,
		CLN_NORMAL = 2'd1,
		CLN_BOOST  = 2'd2
	} cleaner_t;

endpackage
`default_nettype wire

### rtl/core/obstacle_avoid_maneuver_sequencer.sv
`default_nettype none
// Obstacle-avoidance maneuver sequencer.
//
// Input stream (s_axis_*): one item per tick carrying the dust flag and the
// front, left and right obstacle flags. Output stream (m_axis_*): one item per
// input item carrying the drive command and the cleaner command.
// The APB port writes boost_duration (address 0) and backup_ticks (address 4);
// it must be written only while the block is idle; the block does not enforce this.
//
// Each accepted item passes through the input register and then the result
// register; m_axis_tvalid rises when the result register is loaded. The
// block takes one item per cycle while the receiver does not stall, with the
// pending-run counter and the boost countdown between those two registers
// updated once per item.
//
// Reset clears the pending run, the boost countdown and both valid flags, and
// loads boost_duration = 20, backup_ticks = 3.
// When the receiver stalls, the result register holds its item and the input
// register holds the next one; s_axis_tready drops only when both are full.
module obstacle_avoid_maneuver_sequencer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// Input item
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [0] dust_seen, [1] blocked_front, [2] blocked_left, [3] blocked_right
	input  wire  [oams_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// Result item
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [2:0] drive, [4:3] cleaner
	output logic [oams_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// Configuration
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [oams_pkg::APB_AW-1:0]           paddr,
	input  wire  [oams_pkg::APB_DW-1:0]           pwdata,
	output logic [oams_pkg::APB_DW-1:0]           prdata,
	output logic                                  pready
);
	import oams_pkg::*;

	// Configuration registers
	logic [BOOST_W-1:0]  boost_dur_q;
	logic [BACKUP_W-1:0] backup_q;
	logic                cfg_wr;

	// Input stage
	logic valid_s1;
	logic dust_s1, front_s1, left_s1, right_s1;

	// Result stage
	logic                out_valid_q;
	drive_t              drive_q;
	cleaner_t            cleaner_q;

	// Sequencer state. The pending run is always a tail of
	// "backward x n, turn, forward", so the stack reduces to a count of moves
	// left and the direction of the turn: with k moves left the next one is
	// forward when k = 1, the turn when k = 2, backward otherwise.
	logic [CNT_W-1:0]   cnt_q;
	logic               turn_right_q;
	logic [BOOST_W-1:0] boost_left_q;

	logic               advance;
	logic [BOOST_W-1:0] boost_eff;
	logic               use_boost;
	logic [CNT_W-1:0]   n_sat;
	logic [CNT_W-1:0]   cnt_d;
	logic               turn_d;
	logic [BOOST_W-1:0] boost_d;
	drive_t             drive_c;
	cleaner_t           cleaner_c;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_dur_q <= BOOST_DURATION_RST;
			backup_q    <= BACKUP_TICKS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BOOST_DURATION) begin
				boost_dur_q <= pwdata[BOOST_W-1:0];
			end else begin
				backup_q <= pwdata[BACKUP_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_BACKUP_TICKS) begin
			prdata = {{(APB_DW-BACKUP_W){1'b0}}, backup_q};
		end else begin
			prdata = {{(APB_DW-BOOST_W){1'b0}}, boost_dur_q};
		end
	end

	// ---------------- handshake ----------------
	// Advance the input stage whenever the result register is free or drains.
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			dust_s1  <= s_axis_tdata[0];
			front_s1 <= s_axis_tdata[1];
			left_s1  <= s_axis_tdata[2];
			right_s1 <= s_axis_tdata[3];
		end
	end

	// ---------------- decision logic ----------------
	// Saturate the backward run length
	assign n_sat = (int'(backup_q) > MAX_BACKUP) ? CNT_W'(MAX_BACKUP) : CNT_W'(backup_q);

	always_comb begin
		// Dust reloads the countdown before anything else this tick
		boost_eff = dust_s1 ? boost_dur_q : boost_left_q;
		use_boost = 1'b0;
		drive_c   = DRV_FWD;
		cleaner_c = CLN_NORMAL;
		cnt_d     = cnt_q;
		turn_d    = turn_right_q;
		if (cnt_q != '0) begin
			// Pop the next pending move; obstacles are ignored
			cnt_d = cnt_q - 1'b1;
			if (cnt_d == '0) begin
				use_boost = (boost_eff != '0);
			end else if (cnt_d == CNT_W'(1)) begin
				drive_c   = turn_right_q ? DRV_RIGHT : DRV_LEFT;
				cleaner_c = CLN_OFF;
			end else begin
				drive_c   = DRV_BACK;
				cleaner_c = CLN_OFF;
			end
		end else if (!front_s1) begin
			use_boost = (boost_eff != '0);
		end else if (left_s1 && right_s1) begin
			// Dead end: back up, turn left, then forward
			turn_d    = 1'b0;
			cnt_d     = n_sat + 1'b1;
			cleaner_c = CLN_OFF;
			drive_c   = (n_sat != '0) ? DRV_BACK : DRV_LEFT;
		end else begin
			// Stop, turn away from the blocked side, then forward
			turn_d    = left_s1;
			cnt_d     = CNT_W'(2);
			drive_c   = DRV_STOP;
			cleaner_c = CLN_OFF;
		end
		boost_d = boost_eff;
		if (use_boost) begin
			cleaner_c = CLN_BOOST;
			boost_d   = boost_eff - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			turn_right_q <= 1'b0;
			boost_left_q <= '0;
		end else if (advance) begin
			cnt_q        <= cnt_d;
			turn_right_q <= turn_d;
			boost_left_q <= boost_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q   <= drive_c;
			cleaner_q <= cleaner_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-DRIVE_W-CLEAN_W){1'b0}}, cleaner_q, drive_q};

	// ---------------- assertions ----------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_BACKUP + 1)
		else $error("pending run longer than an escape");

	a_cnt_pop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt_q != '0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pending run not popped by one");

	a_pop_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt_q != '0 |-> drive_c != DRV_STOP)
		else $error("stop issued from the pending run");

	a_boost_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cleaner_q == CLN_BOOST |-> drive_q == DRV_FWD)
		else $error("boost cleaning on a non-forward move");

endmodule
`default_nettype wire
